[rtl/central_moment_engine_assert.svh]
// Assertion helpers for the central moment engine.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef CENTRAL_MOMENT_ENGINE_ASSERT_SVH
`define CENTRAL_MOMENT_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define CME_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cme_pkg.sv]
`timescale 1ns / 1ps

package cme_pkg;

  // Accumulator and result width.
  localparam int ACC_W = 64;

  // Register map: word index of each register (paddr[2]).
  localparam logic REG_MOMENT_ORDER = 1'b0;
  localparam logic [1:0] ORDER_RESET = 2'd2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MEAN_PREP,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_READ,
    ST_DIFF,
    ST_SQ,
    ST_CLO,
    ST_CHI,
    ST_TERM,
    ST_ACC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } cme_state_t;

  // Operand choice of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_SQ,
    MUL_CLO,
    MUL_CHI
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mag_ld;
    logic     div_start;
    logic     div_sel_mean;
    logic     mean_ld;
    logic     rd_en;
    logic     diff_ld;
    logic     mul_ld;
    mul_sel_t mul_sel;
    logic     term_ld;
    logic     acc_ld;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic idx_last;
  } sts_t;

endpackage

[rtl/cme_ram.sv]
`timescale 1ns / 1ps

module cme_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/cme_divider.sv]
`timescale 1ns / 1ps

// Unsigned restoring divider, one quotient bit per cycle.
module cme_divider
  import cme_pkg::*;
#(
  parameter int DIV_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ACC_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic [ACC_W-1:0] quotient
);

  localparam int CW = $clog2(ACC_W);

  logic [ACC_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [CW-1:0]    cnt;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial    = {rem, quo[ACC_W-1]};
  assign fits     = trial >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == CW'(ACC_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_W'(trial - {1'b0, dsr});
        quo <= {quo[ACC_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[ACC_W-2:0], 1'b0};
      end
    end
  end

endmodule

[rtl/cme_datapath.sv]
`timescale 1ns / 1ps

module cme_datapath
  import cme_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 12,
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [1:0]             order,
  output logic [ACC_W-1:0]       moment,
  output logic [CNT_W-1:0]       sample_count,
  output logic                   overflowed
);

  localparam int AW     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int MEAN_W = SAMPLE_BITS + 5;
  localparam int D_W    = SAMPLE_BITS + 6;
  localparam int MAG_W  = SAMPLE_BITS + 4;
  localparam int DIV_W  = CNT_W + 1;

  // load side
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] sum;
  logic             dropped;
  logic             full;

  // mean
  logic              sum_neg;
  logic [SUM_W-1:0]  sum_mag;
  logic [MEAN_W-1:0] mean16;
  logic [MEAN_W-1:0] q_mean;

  // second pass
  logic [CNT_W-1:0]       idx;
  logic [SAMPLE_BITS-1:0] rdata;
  logic [D_W-1:0]         x16;
  logic [D_W-1:0]         mean_ext;
  logic [D_W-1:0]         diff_a;
  logic [D_W-1:0]         diff_b;
  logic                   d_neg;
  logic [MAG_W-1:0]       d_mag;
  logic [MAG_W-1:0]       mul_a;
  logic [2*MAG_W-1:0]     prod;
  logic [2*MAG_W-1:0]     sq;
  logic [2*MAG_W-1:0]     plo;
  logic [2*MAG_W-1:0]     phi;
  logic [3*MAG_W-1:0]     cube;
  logic [ACC_W-1:0]       term_mag;
  logic                   term_neg;
  logic [ACC_W-1:0]       acc;
  logic [ACC_W:0]         acc_sum;
  logic                   sat;

  // divider
  logic             acc_neg;
  logic [ACC_W-1:0] div_dvd;
  logic [DIV_W-1:0] div_dsr;
  logic [ACC_W-1:0] quo;
  logic             div_busy;

  assign full = count == CNT_W'(MAX_SAMPLES);

  cme_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load && !full),
    .waddr (count[AW-1:0]),
    .wdata (sample),
    .re    (cmd.rd_en),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sum     <= '0;
      dropped <= 1'b0;
    end else if (cmd.out_ld) begin
      count   <= '0;
      sum     <= '0;
      dropped <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        count <= count + CNT_W'(1);
        sum   <= sum + {{(SUM_W - SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
      end
    end
  end

  // Mean: round(|16*sum| / n) = (2*|16*sum| + n) / (2n), sign restored after.
  assign div_dvd = cmd.div_sel_mean ? ACC_W'({sum_mag, 5'b0}) + ACC_W'(count)
                                    : (acc[ACC_W-1] ? -acc : acc);
  assign div_dsr = cmd.div_sel_mean ? {count, 1'b0} : {1'b0, count};
  assign q_mean  = quo[MEAN_W-1:0];

  cme_divider #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.mag_ld) begin
      sum_neg <= sum[SUM_W-1];
      sum_mag <= sum[SUM_W-1] ? -sum : sum;
    end
    if (cmd.mean_ld) begin
      mean16 <= sum_neg ? -q_mean : q_mean;
    end
    if (cmd.div_start && !cmd.div_sel_mean) begin
      acc_neg <= acc[ACC_W-1];
    end
  end

  // Deviation: both differences in parallel, pick the non-negative one.
  assign x16      = {{2{rdata[SAMPLE_BITS-1]}}, rdata, 4'b0000};
  assign mean_ext = {mean16[MEAN_W-1], mean16};
  assign diff_a   = x16 - mean_ext;
  assign diff_b   = mean_ext - x16;

  always_comb begin
    case (cmd.mul_sel)
      MUL_SQ:  mul_a = d_mag;
      MUL_CLO: mul_a = sq[MAG_W-1:0];
      MUL_CHI: mul_a = sq[2*MAG_W-1:MAG_W];
      default: mul_a = d_mag;
    endcase
  end

  assign prod = mul_a * d_mag;
  assign cube = {phi, {MAG_W{1'b0}}} + (3*MAG_W)'(plo);

  always_ff @(posedge clk) begin
    if (cmd.diff_ld) begin
      d_neg <= diff_a[D_W-1];
      d_mag <= diff_a[D_W-1] ? diff_b[MAG_W-1:0] : diff_a[MAG_W-1:0];
    end
    if (cmd.mul_ld) begin
      case (cmd.mul_sel)
        MUL_SQ:  sq  <= prod;
        MUL_CLO: plo <= prod;
        MUL_CHI: phi <= prod;
        default: sq  <= prod;
      endcase
    end
    if (cmd.term_ld) begin
      term_neg <= d_neg & order[0];
      case (order)
        2'd0:    term_mag <= ACC_W'(1);
        2'd1:    term_mag <= ACC_W'(d_mag);
        2'd2:    term_mag <= ACC_W'(sq);
        2'd3:    term_mag <= ACC_W'(cube);
        default: term_mag <= ACC_W'(1);
      endcase
    end
  end

  // Saturating accumulate on a 65-bit sum.
  assign acc_sum = term_neg ? {acc[ACC_W-1], acc} - {1'b0, term_mag}
                            : {acc[ACC_W-1], acc} + {1'b0, term_mag};

  always_ff @(posedge clk) begin
    if (cmd.mean_ld) begin
      acc <= '0;
      sat <= 1'b0;
      idx <= '0;
    end else if (cmd.acc_ld) begin
      idx <= idx + CNT_W'(1);
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
        sat <= 1'b1;
        acc <= acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc <= acc_sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      moment       <= acc_neg ? -quo : quo;
      sample_count <= count;
      overflowed   <= dropped | sat;
    end
  end

  assign sts.div_busy = div_busy;
  assign sts.idx_last = (idx + CNT_W'(1)) == count;

endmodule

[rtl/cme_ctrl.sv]
`timescale 1ns / 1ps

module cme_ctrl
  import cme_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tlast,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  cme_state_t state;
  cme_state_t state_next;
  logic       m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  assign s_tready = state == ST_LOAD;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (s_tlast) begin
            state_next = ST_MEAN_PREP;
          end
        end
      end
      ST_MEAN_PREP: begin
        cmd.mag_ld = 1'b1;
        state_next = ST_MEAN_GO;
      end
      ST_MEAN_GO: begin
        cmd.div_start    = 1'b1;
        cmd.div_sel_mean = 1'b1;
        state_next       = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (!sts.div_busy) begin
          cmd.mean_ld = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff_ld = 1'b1;
        state_next  = ST_SQ;
      end
      ST_SQ: begin
        cmd.mul_ld  = 1'b1;
        cmd.mul_sel = MUL_SQ;
        state_next  = ST_CLO;
      end
      ST_CLO: begin
        cmd.mul_ld  = 1'b1;
        cmd.mul_sel = MUL_CLO;
        state_next  = ST_CHI;
      end
      ST_CHI: begin
        cmd.mul_ld  = 1'b1;
        cmd.mul_sel = MUL_CHI;
        state_next  = ST_TERM;
      end
      ST_TERM: begin
        cmd.term_ld = 1'b1;
        state_next  = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_ld = 1'b1;
        state_next = sts.idx_last ? ST_DIV_GO : ST_READ;
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!sts.div_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_ld = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_ld) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

endmodule

[rtl/central_moment_engine.sv]
// channel   | direction | signals                         | beat contents
// ----------+-----------+---------------------------------+--------------------------------
// s_*       | in        | s_tvalid s_tready s_tdata s_tlast | one sample, tlast closes the set
// m_*       | out       | m_tvalid m_tready m_tdata m_tuser | moment, sample count, overflow
// apb       | in/out    | psel penable pwrite paddr pwdata  | moment_order at byte address 0
//
// Samples load at one beat per cycle into a store with separate write and read ports
// while the sum is kept. After the beat with tlast, the result beat waits on two 64-step
// passes of the shared radix-2 divider (mean, then final divide) and seven sequencer steps
// per stored sample (store read, deviation, three multiplier uses, term, add).
// s_tready stays low during that time; the result sits in an output register, so a new
// set loads while it waits. Reset (rst, synchronous) empties the set and sets order to 2.
`timescale 1ns / 1ps
`include "central_moment_engine_assert.svh"

module central_moment_engine
  import cme_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 12,
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((ACC_W + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // sample stream
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // [SAMPLE_BITS-1:0] sample, rest zero
  input  logic             s_tlast,   // last_sample
  // result stream
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // [63:0] moment, then sample_count, rest zero
  output logic             m_tuser,   // overflowed
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cmd_t cmd;
  sts_t sts;

  logic [1:0]       order;
  logic [ACC_W-1:0] moment;
  logic [CNT_W-1:0] sample_count;
  logic             overflowed;

  // Register file: one 2-bit register. Word index is paddr[2].
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MOMENT_ORDER) ? {30'b0, order} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= ORDER_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MOMENT_ORDER) begin
      order <= pwdata[1:0];
    end
  end

  cme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cme_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .sample       (s_tdata[SAMPLE_BITS-1:0]),
    .order        (order),
    .moment       (moment),
    .sample_count (sample_count),
    .overflowed   (overflowed)
  );

  assign m_tdata = OUT_W'({sample_count, moment});
  assign m_tuser = overflowed;

  // Loading only while the divider is quiet.
  `CME_ASSERT_IMPLIES(a_ready_div_idle, s_tready, !sts.div_busy, "s_tready while divider busy")
  // The set closes on its last beat.
  `CME_ASSERT_NEXT(a_last_closes, s_tvalid && s_tready && s_tlast, !s_tready, "load after last")
  // A pending result is never overwritten.
  `CME_ASSERT_IMPLIES(a_out_slot_free, cmd.out_ld, !m_tvalid || m_tready, "result overwritten")
  // A result always reports at least one sample.
  `CME_ASSERT_IMPLIES(a_count_nonzero, m_tvalid, sample_count != '0, "empty result")

endmodule

[verif/central_moment_checker.sv]
`timescale 1ns / 1ps

// Watches the sample, result and register channels of the moment engine,
// predicts each result beat and compares it field by field.
module central_moment_checker
  import cme_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] sample, rest zero
  input  logic        s_tlast,   // last_sample
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,   // [63:0] moment, [74:64] sample_count, rest zero
  input  logic        m_tuser,   // overflowed
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          moments_owed
);

  localparam int     STORE_DEPTH = 1024;
  localparam longint ACC_HI = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_LO = 64'h8000_0000_0000_0000;

  typedef struct {
    logic [63:0] moment;
    logic [10:0] n_used;
    logic        ovf;
  } moment_beat_t;

  logic signed [11:0] sample_mem [STORE_DEPTH];
  int                 fill;
  longint             sum_acc;
  bit                 drop_seen;
  logic [1:0]         order;
  moment_beat_t       owed_q [$];
  moment_beat_t       head;
  int                 errs;

  function automatic longint raise_to(longint d, logic [1:0] e);
    case (e)
      2'd0: return 64'sd1;
      2'd1: return d;
      2'd2: return d * d;
      default: return d * d * d;
    endcase
  endfunction

  task automatic take_sample(logic signed [11:0] x, logic last);
    longint       s16, mag, q, mean16, acc, term, d, n;
    bit           sat;
    int           i;
    moment_beat_t r;
    sat = 1'b0;
    if (fill < STORE_DEPTH) begin
      sample_mem[fill] = x;
      fill++;
      sum_acc += x;
    end else begin
      drop_seen = 1'b1;
    end
    if (last) begin
      n = longint'(fill);
      s16 = sum_acc * 16;
      mag = (s16 < 0) ? -s16 : s16;
      // mean rounded to nearest, halves away from zero
      q = (2 * mag + n) / (2 * n);
      mean16 = (s16 < 0) ? -q : q;
      acc = 0;
      for (i = 0; i < fill; i++) begin
        d = 16 * longint'(sample_mem[i]) - mean16;
        term = raise_to(d, order);
        if (term > 0 && acc > ACC_HI - term) begin
          acc = ACC_HI;
          sat = 1'b1;
        end else if (term < 0 && acc < ACC_LO - term) begin
          acc = ACC_LO;
          sat = 1'b1;
        end else begin
          acc += term;
        end
      end
      r.moment = acc / n;
      r.n_used = fill[10:0];
      r.ovf    = drop_seen | sat;
      owed_q.push_back(r);
      fill = 0;
      sum_acc = 0;
      drop_seen = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      sum_acc = 0;
      drop_seen = 1'b0;
      order = ORDER_RESET;
      owed_q.delete();
      errs = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_MOMENT_ORDER)
        order = pwdata[1:0];
      if (s_tvalid && s_tready)
        take_sample(s_tdata[11:0], s_tlast);
      if (m_tvalid && m_tready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result beat: moment %h count %0d ovf %b",
                   $time, m_tdata[63:0], m_tdata[74:64], m_tuser);
          errs++;
        end else begin
          head = owed_q.pop_front();
          if (m_tdata[63:0] !== head.moment) begin
            $display("%0t: moment expected %h got %h", $time, head.moment, m_tdata[63:0]);
            errs++;
          end
          if (m_tdata[74:64] !== head.n_used) begin
            $display("%0t: sample_count expected %0d got %0d", $time, head.n_used,
                     m_tdata[74:64]);
            errs++;
          end
          if (m_tuser !== head.ovf) begin
            $display("%0t: overflowed expected %b got %b", $time, head.ovf, m_tuser);
            errs++;
          end
        end
      end
    end
    mismatches   <= errs;
    moments_owed <= owed_q.size();
  end

endmodule

[verif/central_moment_engine_tb.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the central moment engine. The checker beside the
// DUT predicts every result beat; this module only drives beats and back-pressure,
// writes the order register between sets, and reports.
module central_moment_engine_tb
  import cme_pkg::*;
;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;     // [11:0] sample, rest zero
  logic        s_tlast = 1'b0;   // last_sample
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;          // [63:0] moment, [74:64] sample_count, rest zero
  logic        m_tuser;          // overflowed
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int moments_owed;

  // idle odds in percent, changed per phase
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int beats_sent = 0;
  int cycle_count = 0;

  central_moment_engine DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  central_moment_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .mismatches   (mismatches),
    .moments_owed (moments_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure, one draw per cycle.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Hard stop in case the DUT hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // One sample beat. A random gap may first lower tvalid; with no gap,
  // tvalid stays high and only data and tlast change.
  task automatic send_beat(logic [11:0] x, logic last);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, x};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Random data set of n samples, tlast on the final one. Mix of rail values,
  // a tight cluster near zero and full-range noise.
  task automatic send_set(int n);
    logic [11:0] x;
    int          k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: x = 12'h800;
        1: x = 12'h7FF;
        2, 3, 4: x = 12'($urandom_range(15)) - 12'd8;
        default: x = 12'($urandom());
      endcase
      send_beat(x, k == n - 1);
      beats_sent++;
    end
  endtask

  // Hold the sample side until every result is out, then a short settle.
  // The first edge lets the checker's owed count catch the last beat.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (moments_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write of moment_order: setup, then access. Upper data bits are junk.
  task automatic write_order(logic [1:0] r);
    logic [31:0] w;
    w = $urandom();
    w[1:0] = r;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MOMENT_ORDER, 2'b00};
    pwdata  <= w;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int src_tab [4];
    int sink_tab [4];
    int phase;
    int grp;
    int sel;
    int n;
    int goal;
    src_tab  = '{0, 73, 0, 17};
    sink_tab = '{0, 0, 73, 17};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed sets, no idling.
    // Single sample at the negative rail: zero deviation.
    write_order(2'd3);
    send_beat(12'h800, 1'b1);
    // Rails mixed, cubed deviations of both signs.
    send_beat(12'h7FF, 1'b0);
    send_beat(12'h800, 1'b0);
    send_beat(12'h7FF, 1'b1);
    drain_results();
    // Order zero: every term is one.
    write_order(2'd0);
    send_beat(12'd5, 1'b0);
    send_beat(12'hFF9, 1'b1);
    drain_results();
    // First order, mean 16/3 rounds down.
    write_order(2'd1);
    send_beat(12'd1, 1'b0);
    send_beat(12'd0, 1'b0);
    send_beat(12'd0, 1'b1);
    drain_results();
    // Variance: negative mean -32/3 rounds away from zero; then rails, all-ones and one.
    write_order(2'd2);
    send_beat(12'hFFE, 1'b0);
    send_beat(12'd0, 1'b0);
    send_beat(12'd0, 1'b1);
    send_beat(12'h800, 1'b0);
    send_beat(12'h800, 1'b0);
    send_beat(12'h7FF, 1'b0);
    send_beat(12'h7FF, 1'b0);
    send_beat(12'hFFF, 1'b0);
    send_beat(12'd1, 1'b1);
    drain_results();
    write_order(2'd3);
    send_beat(12'h800, 1'b0);
    send_beat(12'h7FF, 1'b0);
    send_beat(12'h7FF, 1'b0);
    send_beat(12'h7FF, 1'b0);
    send_beat(12'h800, 1'b1);

    // Random phases: none, source gaps, sink stalls, both.
    goal = 0;
    for (phase = 0; phase < 4; phase++) begin
      src_idle_pct   = src_tab[phase];
      sink_stall_pct = sink_tab[phase];
      if (phase == 2) begin
        // Store overflow: between one and six samples past capacity are dropped and flagged.
        drain_results();
        write_order(2'd3);
        send_set(1024 + $urandom_range(1, 6));
      end
      goal = beats_sent + 200;
      grp = 0;
      while (beats_sent < goal) begin
        drain_results();
        write_order(2'(grp + phase));
        repeat ($urandom_range(1, 4)) begin
          sel = $urandom_range(9);
          if (sel < 7)
            n = $urandom_range(1, 8);
          else if (sel < 9)
            n = $urandom_range(9, 40);
          else
            n = 32 * $urandom_range(1, 3);   // sizes where the mean can land on a half
          send_set(n);
        end
        grp++;
      end
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && moments_owed == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/cme_pkg.sv
rtl/cme_ram.sv
rtl/cme_divider.sv
rtl/cme_datapath.sv
rtl/cme_ctrl.sv
rtl/central_moment_engine.sv
verif/central_moment_checker.sv
verif/central_moment_engine_tb.sv
